@@ src/tpc_pkg.sv @@
`timescale 1ns / 1ps

package tpc_pkg;

    // width of one partial product operand in the pipelined multipliers
    localparam int MUL_CHUNK = 32;

    // curvature result width and the quotient that feeds its square root
    localparam int CURV_W = 32;
    localparam int QUOT_W = 2 * CURV_W;

    // flags that ride along with an item through the divide and root stages
    typedef struct packed {
        logic zero;
        logic sat;
    } flags_t;

endpackage

@@ src/tpc_in_if.sv @@
`timescale 1ns / 1ps

interface tpc_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] first_x;
    logic signed [COORD_WIDTH-1:0] first_y;
    logic signed [COORD_WIDTH-1:0] middle_x;
    logic signed [COORD_WIDTH-1:0] middle_y;
    logic signed [COORD_WIDTH-1:0] last_x;
    logic signed [COORD_WIDTH-1:0] last_y;

    modport source (
        output valid, first_x, first_y, middle_x, middle_y, last_x, last_y,
        input  ready
    );
    modport sink (
        input  valid, first_x, first_y, middle_x, middle_y, last_x, last_y,
        output ready
    );
endinterface

@@ src/tpc_out_if.sv @@
`timescale 1ns / 1ps

interface tpc_out_if;
    logic                        valid;
    logic                        ready;
    logic [tpc_pkg::CURV_W-1:0]  curvature;
    logic                        collinear;
    logic                        saturated;

    modport source (
        output valid, curvature, collinear, saturated,
        input  ready
    );
    modport sink (
        input  valid, curvature, collinear, saturated,
        output ready
    );
endinterface

@@ src/tpc_mul.sv @@
`timescale 1ns / 1ps

module tpc_mul #(
    parameter int A_W   = 49,
    parameter int B_W   = 49,
    parameter int TAG_W = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [A_W-1:0]       a,
    input  logic [B_W-1:0]       b,
    input  logic [TAG_W-1:0]     in_tag,
    output logic                 out_valid,
    output logic [A_W+B_W-1:0]   p,
    output logic [TAG_W-1:0]     out_tag
);
    localparam int CW = tpc_pkg::MUL_CHUNK;
    localparam int NA = (A_W + CW - 1) / CW;
    localparam int NB = (B_W + CW - 1) / CW;
    localparam int SW = (NA + NB) * CW;

    logic [NA*CW-1:0]   a_ext;
    logic [NB*CW-1:0]   b_ext;
    logic [2*CW-1:0]    pp_reg [NA][NB];
    logic [TAG_W-1:0]   tag1_reg;
    logic               v1_reg;
    logic [SW-1:0]      acc;
    logic [A_W+B_W-1:0] p_reg;
    logic [TAG_W-1:0]   tag2_reg;
    logic               v2_reg;

    assign a_ext = (NA*CW)'(a);
    assign b_ext = (NB*CW)'(b);

    // partial products, one chunk pair each
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NA; i++)
            begin
                for (int j = 0; j < NB; j++)
                begin
                    pp_reg[i][j] <= a_ext[i*CW +: CW] * b_ext[j*CW +: CW];
                end
            end
            tag1_reg <= in_tag;
        end
    end

    always_comb
    begin
        acc = '0;
        for (int i = 0; i < NA; i++)
        begin
            for (int j = 0; j < NB; j++)
            begin
                acc = acc + (SW'(pp_reg[i][j]) << ((i + j) * CW));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg    <= acc[A_W+B_W-1:0];
            tag2_reg <= tag1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign p         = p_reg;
    assign out_tag   = tag2_reg;
endmodule

@@ src/tpc_div.sv @@
`timescale 1ns / 1ps

module tpc_div #(
    parameter int NUM_W = 148,
    parameter int DEN_W = 147,
    parameter int QUO_W = 64,
    parameter int TAG_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NUM_W-1:0]  num,
    input  logic [DEN_W-1:0]  den,
    input  logic [TAG_W-1:0]  in_tag,
    output logic              out_valid,
    output logic [QUO_W-1:0]  quo,
    output logic              sat,
    output logic [TAG_W-1:0]  out_tag
);
    localparam int HI_W  = NUM_W - QUO_W;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [CMP_W-1:0] hi_ext;
    logic [CMP_W-1:0] den_ext;

    logic [DEN_W-1:0] rem_reg [QUO_W+1];
    logic [QUO_W-1:0] nq_reg  [QUO_W+1];
    logic [DEN_W-1:0] den_reg [QUO_W+1];
    logic [TAG_W-1:0] tag_reg [QUO_W+1];
    logic             sat_reg [QUO_W+1];
    logic             v_reg   [QUO_W+1];

    assign hi_ext  = CMP_W'(num[NUM_W-1:QUO_W]);
    assign den_ext = CMP_W'(den);

    // load: quotient overflows unless the upper part is below the divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= hi_ext[DEN_W-1:0];
            nq_reg[0]  <= num[QUO_W-1:0];
            den_reg[0] <= den;
            tag_reg[0] <= in_tag;
            sat_reg[0] <= (hi_ext >= den_ext);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // one quotient bit per stage, restoring
    for (genvar s = 1; s <= QUO_W; s++)
    begin : g_step
        logic [DEN_W:0] trial;
        logic [DEN_W:0] diff;
        logic           ge;

        always_comb
        begin
            trial = {rem_reg[s-1], nq_reg[s-1][QUO_W-1]};
            diff  = trial - {1'b0, den_reg[s-1]};
            ge    = ~diff[DEN_W];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
                nq_reg[s]  <= {nq_reg[s-1][QUO_W-2:0], ge};
                den_reg[s] <= den_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
                sat_reg[s] <= sat_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_reg[s-1];
        end
    end

    assign out_valid = v_reg[QUO_W];
    assign quo       = nq_reg[QUO_W];
    assign sat       = sat_reg[QUO_W];
    assign out_tag   = tag_reg[QUO_W];
endmodule

@@ src/tpc_sqrt.sv @@
`timescale 1ns / 1ps

module tpc_sqrt #(
    parameter int RAD_W = 64,
    parameter int TAG_W = 2
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  logic [RAD_W-1:0]   rad,
    input  logic [TAG_W-1:0]   in_tag,
    output logic               out_valid,
    output logic [RAD_W/2-1:0] root,
    output logic [TAG_W-1:0]   out_tag
);
    localparam int RT_W = RAD_W / 2;

    logic [RT_W+1:0]  rem_reg  [RT_W+1];
    logic [RT_W-1:0]  root_reg [RT_W+1];
    logic [RAD_W-1:0] q_reg    [RT_W+1];
    logic [TAG_W-1:0] tag_reg  [RT_W+1];
    logic             v_reg    [RT_W+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            q_reg[0]    <= rad;
            tag_reg[0]  <= in_tag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (en)
            v_reg[0] <= in_valid;
    end

    // one root bit per stage, two radicand bits brought down each time
    for (genvar s = 1; s <= RT_W; s++)
    begin : g_step
        logic [RT_W+3:0] t;
        logic [RT_W+3:0] diff;
        logic            ge;

        always_comb
        begin
            t    = {rem_reg[s-1], q_reg[s-1][RAD_W-1:RAD_W-2]};
            diff = t - (RT_W+4)'({root_reg[s-1], 2'b01});
            ge   = ~diff[RT_W+3];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s]  <= ge ? diff[RT_W+1:0] : t[RT_W+1:0];
                root_reg[s] <= {root_reg[s-1][RT_W-2:0], ge};
                q_reg[s]    <= {q_reg[s-1][RAD_W-3:0], 2'b00};
                tag_reg[s]  <= tag_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[s] <= 1'b0;
            else if (en)
                v_reg[s] <= v_reg[s-1];
        end
    end

    assign out_valid = v_reg[RT_W];
    assign root      = root_reg[RT_W];
    assign out_tag   = tag_reg[RT_W];
endmodule

@@ src/three_point_curvature_unit.sv @@
`timescale 1ns / 1ps
// channel   dir   payload                                        accepted when
// in_ch     in    first_x/y, middle_x/y, last_x/y (signed)        valid && ready
// out_ch    out   curvature[31:0], collinear, saturated           valid && ready
//
// one transaction per cycle sustained while out_ch takes results; results pass
// through the divider's 64 quotient-bit stages and the 32 square root stages
// the whole pipeline advances together whenever the output register is
// empty or being taken, so in_ch.ready drops only while a result waits
// reset clears the valid bits of every stage; data registers are not reset

module three_point_curvature_unit #(
    parameter int COORD_WIDTH     = 24,
    parameter int COORD_FRAC_BITS = 8,
    parameter int CURV_FRAC_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    tpc_in_if.sink    in_ch,
    tpc_out_if.source out_ch
);
    localparam int N     = COORD_WIDTH;
    localparam int DW    = N + 1;               // edge vector components
    localparam int LW    = 2 * N + 1;           // squared side lengths
    localparam int DMW   = 2 * N + 1;           // |det|
    localparam int SHIFT = 2 * (COORD_FRAC_BITS + CURV_FRAC_BITS + 1);
    localparam int NUMW  = 2 * DMW + SHIFT;     // (2|det| scaled)^2
    localparam int PW    = 3 * LW;              // product of squared sides
    localparam int QW    = tpc_pkg::QUOT_W;
    localparam int FW    = $bits(tpc_pkg::flags_t);

    logic adv;

    // stage a: edge vectors
    logic                 va_reg;
    logic signed [DW-1:0] ax_reg, ay_reg, bx_reg, by_reg, cx_reg, cy_reg;

    // stage b: cross terms and squares
    logic                   vb_reg;
    logic signed [2*DW-1:0] p_reg, q_reg;
    logic signed [2*DW-1:0] sax_reg, say_reg, sbx_reg, sby_reg, scx_reg, scy_reg;

    // stage c: determinant and squared side lengths
    logic                 vc_reg;
    logic signed [2*DW:0] det_w;
    logic [2*DW:0]        det_abs;
    logic [DMW-1:0]       dm_reg;
    logic                 zero_reg;
    logic [LW-1:0]        la_reg, lb_reg, lc_reg;

    // multiplier outputs
    logic            m1_valid, m2_valid, m3_valid;
    logic [2*LW-1:0] pab;
    logic [LW-1:0]   lc_d;
    logic [2*DMW-1:0] dsq;
    logic            zero_d;
    logic [NUMW-1:0] num;
    logic [PW-1:0]   pr;
    logic [NUMW:0]   m3_tag;

    // divide and root outputs
    logic                        dv_valid;
    logic [QW-1:0]               quo;
    logic                        dv_sat;
    logic                        dv_zero;
    tpc_pkg::flags_t             dv_flags;
    logic                        sq_valid;
    logic [tpc_pkg::CURV_W-1:0]  root;
    tpc_pkg::flags_t             sq_flags;

    // output register
    logic                        out_valid_reg;
    logic [tpc_pkg::CURV_W-1:0]  curv_reg;
    logic                        coll_reg;
    logic                        sat_reg;

    assign adv         = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;

    // stage a
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ax_reg <= {in_ch.middle_x[N-1], in_ch.middle_x} - {in_ch.first_x[N-1], in_ch.first_x};
            ay_reg <= {in_ch.middle_y[N-1], in_ch.middle_y} - {in_ch.first_y[N-1], in_ch.first_y};
            bx_reg <= {in_ch.last_x[N-1], in_ch.last_x} - {in_ch.middle_x[N-1], in_ch.middle_x};
            by_reg <= {in_ch.last_y[N-1], in_ch.last_y} - {in_ch.middle_y[N-1], in_ch.middle_y};
            cx_reg <= {in_ch.last_x[N-1], in_ch.last_x} - {in_ch.first_x[N-1], in_ch.first_x};
            cy_reg <= {in_ch.last_y[N-1], in_ch.last_y} - {in_ch.first_y[N-1], in_ch.first_y};
        end
    end

    // stage b: one multiplier per term
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_reg   <= ax_reg * by_reg;
            q_reg   <= bx_reg * ay_reg;
            sax_reg <= ax_reg * ax_reg;
            say_reg <= ay_reg * ay_reg;
            sbx_reg <= bx_reg * bx_reg;
            sby_reg <= by_reg * by_reg;
            scx_reg <= cx_reg * cx_reg;
            scy_reg <= cy_reg * cy_reg;
        end
    end

    // stage c: det = ax*by - bx*ay, zero means collinear or coincident
    always_comb
    begin
        det_w   = {p_reg[2*DW-1], p_reg} - {q_reg[2*DW-1], q_reg};
        det_abs = det_w[2*DW] ? -det_w : det_w;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dm_reg   <= det_abs[DMW-1:0];
            zero_reg <= (det_w == '0);
            la_reg   <= LW'(sax_reg[2*N-1:0]) + LW'(say_reg[2*N-1:0]);
            lb_reg   <= LW'(sbx_reg[2*N-1:0]) + LW'(sby_reg[2*N-1:0]);
            lc_reg   <= LW'(scx_reg[2*N-1:0]) + LW'(scy_reg[2*N-1:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
        end
        else if (adv)
        begin
            va_reg <= in_ch.valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
        end
    end

    // |a|^2 * |b|^2, with |c|^2 carried alongside
    tpc_mul #(
        .A_W   (LW),
        .B_W   (LW),
        .TAG_W (LW)
    ) u_mul_ab (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vc_reg),
        .a         (la_reg),
        .b         (lb_reg),
        .in_tag    (lc_reg),
        .out_valid (m1_valid),
        .p         (pab),
        .out_tag   (lc_d)
    );

    // det^2 in parallel, carrying the collinear flag
    tpc_mul #(
        .A_W   (DMW),
        .B_W   (DMW),
        .TAG_W (1)
    ) u_mul_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (vc_reg),
        .a         (dm_reg),
        .b         (dm_reg),
        .in_tag    (zero_reg),
        .out_valid (m2_valid),
        .p         (dsq),
        .out_tag   (zero_d)
    );

    // numerator: 4 * det^2 * 2^(2*(coord frac + curv frac))
    assign num = {dsq, SHIFT'(0)};

    tpc_mul #(
        .A_W   (2*LW),
        .B_W   (LW),
        .TAG_W (NUMW+1)
    ) u_mul_abc (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m1_valid && m2_valid),
        .a         (pab),
        .b         (lc_d),
        .in_tag    ({zero_d, num}),
        .out_valid (m3_valid),
        .p         (pr),
        .out_tag   (m3_tag)
    );

    // kappa^2 scaled = num / pr, saturation when it reaches 2^64
    tpc_div #(
        .NUM_W (NUMW),
        .DEN_W (PW),
        .QUO_W (QW),
        .TAG_W (1)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m3_valid),
        .num       (m3_tag[NUMW-1:0]),
        .den       (pr),
        .in_tag    (m3_tag[NUMW]),
        .out_valid (dv_valid),
        .quo       (quo),
        .sat       (dv_sat),
        .out_tag   (dv_zero)
    );

    always_comb
    begin
        dv_flags.zero = dv_zero;
        dv_flags.sat  = dv_sat;
    end

    // floor(sqrt(floor(x))) equals floor(sqrt(x)), so truncation is exact
    tpc_sqrt #(
        .RAD_W (QW),
        .TAG_W (FW)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (dv_valid),
        .rad       (quo),
        .in_tag    (dv_flags),
        .out_valid (sq_valid),
        .root      (root),
        .out_tag   (sq_flags)
    );

    // output register: collinear wins over saturation
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sq_flags.zero)
                curv_reg <= '0;
            else if (sq_flags.sat)
                curv_reg <= '1;
            else
                curv_reg <= root;
            coll_reg <= sq_flags.zero;
            sat_reg  <= !sq_flags.zero && sq_flags.sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sq_valid;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.curvature = curv_reg;
    assign out_ch.collinear = coll_reg;
    assign out_ch.saturated = sat_reg;
endmodule

@@ src/tpc_checker.sv @@
`timescale 1ns / 1ps

module tpc_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [tpc_pkg::CURV_W-1:0] curvature,
    input logic                       collinear,
    input logic                       saturated
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(curvature)
            && $stable(collinear) && $stable(saturated))
        else $error("result changed while stalled");

    // input side only stalls behind a waiting result
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without a waiting result");

    a_collinear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collinear |-> curvature == '0 && !saturated)
        else $error("collinear result not zero");

    a_saturated: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> curvature == '1 && !collinear)
        else $error("saturated result not full scale");
endmodule

bind three_point_curvature_unit tpc_checker u_tpc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .curvature (out_ch.curvature),
    .collinear (out_ch.collinear),
    .saturated (out_ch.saturated)
);
